[hw/rtl/cau_pkg.sv]
// Shared opcodes, control struct and default widths for the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 24;

  typedef enum logic [3:0] {
    OpAdd   = 4'd0,
    OpSub   = 4'd1,
    OpMul   = 4'd2,
    OpDiv   = 4'd3,
    OpInv   = 4'd4,
    OpConj  = 4'd5,
    OpNeg   = 4'd6,
    OpAbs2  = 4'd7,
    OpDiff2 = 4'd8,
    OpScale = 4'd9
  } op_e;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic dz;
  } ctl_t;

endpackage

[hw/rtl/complex_arithmetic_unit.sv]
// Top level of the pipelined complex arithmetic unit.
`timescale 1ns / 1ps
// Fully pipelined: one item may start in every cycle, and busy_o stays low.
// Every opcode passes through the same stages: four front stages for
// operand select, products, sums and rounding, WORD_BITS + 1 divider
// stages that each settle one quotient bit, one stage to apply the
// quotient sign and one output stage that saturates. done_o marks each
// result for exactly one cycle; the receiver has no way to stall it, so
// results must be taken as they come.
module complex_arithmetic_unit #(
  parameter int WORD_BITS = cau_pkg::WordBits,
  parameter int FRAC_BITS = cau_pkg::FracBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [3:0]                  opcode_i,
  input  logic signed [WORD_BITS-1:0] a_real_i,
  input  logic signed [WORD_BITS-1:0] a_imag_i,
  input  logic signed [WORD_BITS-1:0] b_real_i,
  input  logic signed [WORD_BITS-1:0] b_imag_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] r_real_o,
  output logic signed [WORD_BITS-1:0] r_imag_o,
  output logic                        overflow_o,
  output logic                        div_zero_o,
  output logic [1:0]                  nonzero_parts_o
);
  import cau_pkg::*;

  localparam int SumBits = (2*WORD_BITS+3 > WORD_BITS+FRAC_BITS+2) ?
                           2*WORD_BITS+3 : WORD_BITS+FRAC_BITS+2;
  localparam int ValBits = SumBits + 1;
  localparam int RemBits = SumBits + FRAC_BITS + WORD_BITS + 4;

  localparam logic signed [ValBits-1:0] MaxVal =
    {{(ValBits-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [ValBits-1:0] MinVal =
    {{(ValBits-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  ctl_t                      front_ctl, re_ctl, im_ctl;
  logic signed [ValBits-1:0] re_val, im_val, re_res, im_res;
  logic                      re_neg, im_neg;
  logic [RemBits-1:0]        re_rem, im_rem, dsr;

  assign busy_o = 1'b0;

  cau_prod #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .opcode_i(opcode_i),
    .a_real_i(a_real_i),
    .a_imag_i(a_imag_i),
    .b_real_i(b_real_i),
    .b_imag_i(b_imag_i),
    .ctl_o   (front_ctl),
    .re_val_o(re_val),
    .im_val_o(im_val),
    .re_neg_o(re_neg),
    .im_neg_o(im_neg),
    .re_rem_o(re_rem),
    .im_rem_o(im_rem),
    .dsr_o   (dsr)
  );

  cau_div #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_div_re (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (front_ctl),
    .val_i (re_val),
    .neg_i (re_neg),
    .rem_i (re_rem),
    .dsr_i (dsr),
    .ctl_o (re_ctl),
    .val_o (re_res)
  );

  cau_div #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_div_im (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (front_ctl),
    .val_i (im_val),
    .neg_i (im_neg),
    .rem_i (im_rem),
    .dsr_i (dsr),
    .ctl_o (im_ctl),
    .val_o (im_res)
  );

  // clamp each part to the word range
  logic [WORD_BITS-1:0] re_sat, im_sat;
  logic                 re_ovf, im_ovf;

  always_comb begin
    re_ovf = 1'b1;
    if (re_res > MaxVal) begin
      re_sat = MaxVal[WORD_BITS-1:0];
    end else if (re_res < MinVal) begin
      re_sat = MinVal[WORD_BITS-1:0];
    end else begin
      re_sat = re_res[WORD_BITS-1:0];
      re_ovf = 1'b0;
    end
    im_ovf = 1'b1;
    if (im_res > MaxVal) begin
      im_sat = MaxVal[WORD_BITS-1:0];
    end else if (im_res < MinVal) begin
      im_sat = MinVal[WORD_BITS-1:0];
    end else begin
      im_sat = im_res[WORD_BITS-1:0];
      im_ovf = 1'b0;
    end
  end

  // output stage
  logic                 done_q;
  logic [WORD_BITS-1:0] r_real_q, r_imag_q;
  logic                 ovf_q, dz_q;
  logic [1:0]           nz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= re_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    r_real_q <= re_sat;
    r_imag_q <= im_sat;
    ovf_q    <= re_ovf | im_ovf;
    dz_q     <= re_ctl.dz | im_ctl.dz;
    nz_q     <= 2'(re_sat != '0) + 2'(im_sat != '0);
  end

  assign done_o          = done_q;
  assign r_real_o        = r_real_q;
  assign r_imag_o        = r_imag_q;
  assign overflow_o      = ovf_q;
  assign div_zero_o      = dz_q;
  assign nonzero_parts_o = nz_q;

endmodule

[hw/rtl/cau_prod.sv]
// Front pipeline: operand select, products, sums, rounding and divide setup.
`timescale 1ns / 1ps
module cau_prod #(
  parameter int WORD_BITS = cau_pkg::WordBits,
  parameter int FRAC_BITS = cau_pkg::FracBits,
  localparam int SUM_BITS = (2*WORD_BITS+3 > WORD_BITS+FRAC_BITS+2) ?
                            2*WORD_BITS+3 : WORD_BITS+FRAC_BITS+2,
  localparam int VAL_BITS = SUM_BITS + 1,
  localparam int QUO_BITS = WORD_BITS + 1,
  localparam int REM_BITS = SUM_BITS + FRAC_BITS + QUO_BITS + 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [3:0]                  opcode_i,
  input  logic signed [WORD_BITS-1:0] a_real_i,
  input  logic signed [WORD_BITS-1:0] a_imag_i,
  input  logic signed [WORD_BITS-1:0] b_real_i,
  input  logic signed [WORD_BITS-1:0] b_imag_i,
  output cau_pkg::ctl_t               ctl_o,
  output logic signed [VAL_BITS-1:0]  re_val_o,
  output logic signed [VAL_BITS-1:0]  im_val_o,
  output logic                        re_neg_o,
  output logic                        im_neg_o,
  output logic [REM_BITS-1:0]         re_rem_o,
  output logic [REM_BITS-1:0]         im_rem_o,
  output logic [REM_BITS-1:0]         dsr_o
);
  import cau_pkg::*;

  localparam int XB = WORD_BITS + 1;
  localparam int PB = 2 * XB;

  // stage 1: register operands and the squared-term operands
  logic                        v1_q;
  op_e                         op1_q;
  logic signed [WORD_BITS-1:0] ar1_q, ai1_q, br1_q, bi1_q;
  logic signed [XB-1:0]        sx1_d, sy1_d, sx1_q, sy1_q;
  logic signed [XB-1:0]        dx_w, dy_w;

  assign dx_w = XB'(b_real_i) - XB'(a_real_i);
  assign dy_w = XB'(b_imag_i) - XB'(a_imag_i);

  // pick the pair whose squares form the magnitude term
  always_comb begin
    case (op_e'(opcode_i))
      OpDiv: begin
        sx1_d = XB'(b_real_i);
        sy1_d = XB'(b_imag_i);
      end
      OpDiff2: begin
        sx1_d = dx_w;
        sy1_d = dy_w;
      end
      default: begin
        sx1_d = XB'(a_real_i);
        sy1_d = XB'(a_imag_i);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q <= op_e'(opcode_i);
    ar1_q <= a_real_i;
    ai1_q <= a_imag_i;
    br1_q <= b_real_i;
    bi1_q <= b_imag_i;
    sx1_q <= sx1_d;
    sy1_q <= sy1_d;
  end

  // stage 2: form all products
  logic                        v2_q;
  op_e                         op2_q;
  logic signed [WORD_BITS-1:0] ar2_q, ai2_q, br2_q, bi2_q;
  logic signed [PB-1:0]        p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op2_q <= op1_q;
    ar2_q <= ar1_q;
    ai2_q <= ai1_q;
    br2_q <= br1_q;
    bi2_q <= bi1_q;
    p0_q  <= PB'(ar1_q) * PB'(br1_q);
    p1_q  <= PB'(ai1_q) * PB'(bi1_q);
    p2_q  <= PB'(ar1_q) * PB'(bi1_q);
    p3_q  <= PB'(ai1_q) * PB'(br1_q);
    p4_q  <= PB'(sx1_q) * PB'(sx1_q);
    p5_q  <= PB'(sy1_q) * PB'(sy1_q);
  end

  // stage 3: sum products or form the simple results
  logic                       v3_q;
  op_e                        op3_q;
  logic signed [SUM_BITS-1:0] re3_d, im3_d, re3_q, im3_q;
  logic [SUM_BITS-1:0]        den3_d, den3_q;

  assign den3_d = SUM_BITS'(p4_q) + SUM_BITS'(p5_q);

  always_comb begin
    re3_d = '0;
    im3_d = '0;
    case (op2_q)
      OpAdd: begin
        re3_d = SUM_BITS'(ar2_q) + SUM_BITS'(br2_q);
        im3_d = SUM_BITS'(ai2_q) + SUM_BITS'(bi2_q);
      end
      OpSub: begin
        re3_d = SUM_BITS'(ar2_q) - SUM_BITS'(br2_q);
        im3_d = SUM_BITS'(ai2_q) - SUM_BITS'(bi2_q);
      end
      OpMul: begin
        re3_d = SUM_BITS'(p0_q) - SUM_BITS'(p1_q);
        im3_d = SUM_BITS'(p2_q) + SUM_BITS'(p3_q);
      end
      OpDiv: begin
        re3_d = SUM_BITS'(p0_q) + SUM_BITS'(p1_q);
        im3_d = SUM_BITS'(p3_q) - SUM_BITS'(p2_q);
      end
      OpInv: begin
        re3_d = SUM_BITS'(ar2_q) <<< FRAC_BITS;
        im3_d = -(SUM_BITS'(ai2_q) <<< FRAC_BITS);
      end
      OpConj: begin
        re3_d = SUM_BITS'(ar2_q);
        im3_d = -SUM_BITS'(ai2_q);
      end
      OpNeg: begin
        re3_d = -SUM_BITS'(ar2_q);
        im3_d = -SUM_BITS'(ai2_q);
      end
      OpAbs2, OpDiff2: begin
        re3_d = SUM_BITS'(p4_q) + SUM_BITS'(p5_q);
      end
      OpScale: begin
        re3_d = SUM_BITS'(p0_q);
        im3_d = SUM_BITS'(p3_q);
      end
      default: begin
        re3_d = '0;
        im3_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op3_q  <= op2_q;
    re3_q  <= re3_d;
    im3_q  <= im3_d;
    den3_q <= den3_d;
  end

  // stage 4: round products, or set up the quotient lanes
  function automatic logic [VAL_BITS-1:0] abs_val(input logic signed [SUM_BITS-1:0] s);
    logic [VAL_BITS-1:0] m;
    m = VAL_BITS'(s);
    if (s[SUM_BITS-1]) begin
      m = -m;
    end
    return m;
  endfunction

  // shift out the fraction, nearest with ties away from zero
  function automatic logic signed [VAL_BITS-1:0] round_fix(
    input logic signed [SUM_BITS-1:0] s
  );
    logic [VAL_BITS-1:0] m;
    m = abs_val(s);
    m = (m + (VAL_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return s[SUM_BITS-1] ? -$signed(m) : $signed(m);
  endfunction

  logic                       has_div;
  logic                       den_zero;
  cau_pkg::ctl_t              ctl_d;
  logic signed [VAL_BITS-1:0] re_val_d, im_val_d;
  logic [REM_BITS-1:0]        re_rem_d, im_rem_d, dsr_d;

  assign has_div  = op3_q inside {OpDiv, OpInv};
  assign den_zero = (den3_q == '0);

  assign ctl_d.valid  = v3_q;
  assign ctl_d.is_div = has_div && !den_zero;
  assign ctl_d.dz     = has_div && den_zero;

  assign re_rem_d = (REM_BITS'(abs_val(re3_q)) << (FRAC_BITS + 1)) + REM_BITS'(den3_q);
  assign im_rem_d = (REM_BITS'(abs_val(im3_q)) << (FRAC_BITS + 1)) + REM_BITS'(den3_q);
  assign dsr_d    = REM_BITS'(den3_q) << 1;

  always_comb begin
    case (op3_q)
      OpMul, OpAbs2, OpDiff2, OpScale: begin
        re_val_d = round_fix(re3_q);
        im_val_d = round_fix(im3_q);
      end
      OpAdd, OpSub, OpConj, OpNeg: begin
        re_val_d = VAL_BITS'(re3_q);
        im_val_d = VAL_BITS'(im3_q);
      end
      default: begin
        re_val_d = '0;
        im_val_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    re_val_o <= re_val_d;
    im_val_o <= im_val_d;
    re_neg_o <= re3_q[SUM_BITS-1];
    im_neg_o <= im3_q[SUM_BITS-1];
    re_rem_o <= re_rem_d;
    im_rem_o <= im_rem_d;
    dsr_o    <= dsr_d;
  end

endmodule

[hw/rtl/cau_div.sv]
// Pipelined restoring divider lane: one quotient bit per stage, with bypass value.
`timescale 1ns / 1ps
module cau_div #(
  parameter int WORD_BITS = cau_pkg::WordBits,
  parameter int FRAC_BITS = cau_pkg::FracBits,
  localparam int SUM_BITS = (2*WORD_BITS+3 > WORD_BITS+FRAC_BITS+2) ?
                            2*WORD_BITS+3 : WORD_BITS+FRAC_BITS+2,
  localparam int VAL_BITS = SUM_BITS + 1,
  localparam int QUO_BITS = WORD_BITS + 1,
  localparam int REM_BITS = SUM_BITS + FRAC_BITS + QUO_BITS + 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cau_pkg::ctl_t              ctl_i,
  input  logic signed [VAL_BITS-1:0] val_i,
  input  logic                       neg_i,
  input  logic [REM_BITS-1:0]        rem_i,
  input  logic [REM_BITS-1:0]        dsr_i,
  output cau_pkg::ctl_t              ctl_o,
  output logic signed [VAL_BITS-1:0] val_o
);
  import cau_pkg::*;

  ctl_t                       ctl_q [QUO_BITS];
  logic signed [VAL_BITS-1:0] val_q [QUO_BITS];
  logic                       neg_q [QUO_BITS];
  logic                       ovf_q [QUO_BITS];
  logic [REM_BITS-1:0]        rem_q [QUO_BITS];
  logic [REM_BITS-1:0]        dsr_q [QUO_BITS];
  logic [QUO_BITS-1:0]        quo_q [QUO_BITS];

  for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
    localparam int Shift = QUO_BITS - 1 - s;

    ctl_t                       ctl_in;
    logic signed [VAL_BITS-1:0] val_in;
    logic                       neg_in, ovf_in;
    logic [REM_BITS-1:0]        rem_in, dsr_in, trial;
    logic [QUO_BITS-1:0]        quo_in;
    logic                       fits;

    if (s == 0) begin : g_first
      // quotient too large for the word: flag it up front
      assign ctl_in = ctl_i;
      assign val_in = val_i;
      assign neg_in = neg_i;
      assign rem_in = rem_i;
      assign dsr_in = dsr_i;
      assign quo_in = '0;
      assign ovf_in = (rem_i >= (dsr_i << QUO_BITS));
    end else begin : g_next
      assign ctl_in = ctl_q[s-1];
      assign val_in = val_q[s-1];
      assign neg_in = neg_q[s-1];
      assign rem_in = rem_q[s-1];
      assign dsr_in = dsr_q[s-1];
      assign quo_in = quo_q[s-1];
      assign ovf_in = ovf_q[s-1];
    end

    // trial subtract of the divisor at this bit weight
    assign trial = dsr_in << Shift;
    assign fits  = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s] <= '0;
      end else begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      val_q[s] <= val_in;
      neg_q[s] <= neg_in;
      ovf_q[s] <= ovf_in;
      dsr_q[s] <= dsr_in;
      rem_q[s] <= fits ? rem_in - trial : rem_in;
      quo_q[s] <= quo_in | (QUO_BITS'(fits) << Shift);
    end
  end

  // pass the bypass value through for non-divides, else apply the sign, or force a value that saturates on overflow
  localparam int Last = QUO_BITS - 1;

  logic signed [VAL_BITS-1:0] big_w, quo_w, val_d;

  assign big_w = VAL_BITS'(1) <<< WORD_BITS;
  assign quo_w = VAL_BITS'(quo_q[Last]);

  always_comb begin
    if (!ctl_q[Last].is_div) begin
      val_d = val_q[Last];
    end else if (ovf_q[Last]) begin
      val_d = neg_q[Last] ? -big_w : big_w;
    end else begin
      val_d = neg_q[Last] ? -quo_w : quo_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    val_o <= val_d;
  end

endmodule

[hw/rtl/cau_checker.sv]
// Port-level checks for the complex arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
module cau_checker #(
  parameter int WORD_BITS = cau_pkg::WordBits
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [3:0]                  opcode_i,
  input logic signed [WORD_BITS-1:0] a_real_i,
  input logic signed [WORD_BITS-1:0] a_imag_i,
  input logic signed [WORD_BITS-1:0] b_real_i,
  input logic signed [WORD_BITS-1:0] b_imag_i,
  input logic                        done_o,
  input logic signed [WORD_BITS-1:0] r_real_o,
  input logic signed [WORD_BITS-1:0] r_imag_o,
  input logic                        overflow_o,
  input logic                        div_zero_o,
  input logic [1:0]                  nonzero_parts_o
);

  // pipeline never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  // zero divisor gives a clean zero result
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && div_zero_o |-> r_real_o == '0 && r_imag_o == '0 && !overflow_o)
    else $error("divide by zero result not zero");

  // count matches the parts shown
  a_nz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && nonzero_parts_o == 2'd0 |-> r_real_o == '0 && r_imag_o == '0)
    else $error("zero count with nonzero part");

  a_nz_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && nonzero_parts_o == 2'd2 |-> r_real_o != '0 && r_imag_o != '0)
    else $error("count of two with a zero part");

  a_nz_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> nonzero_parts_o != 2'd3)
    else $error("nonzero count out of range");

endmodule

bind complex_arithmetic_unit cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (.*);
